// File: rtl/afu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_pkg
// Shared types and fixed-point constants of the activation function unit.
// ----------------------------------------------------------------------------
package afu_pkg;

   // Internal Q1.30 format of the exp and sigmoid path
   localparam int IQ = 30;
   localparam logic [30:0] IONE  = 31'h4000_0000;
   localparam logic [29:0] IHALF = 30'h2000_0000;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [27:0] FIFTH_Q30 = 28'd214748365;

   // Range reduction: argument clamped to 32, so k never exceeds 46
   localparam int BIG_W  = 36;
   localparam int K_MAX  = 46;
   localparam int K_W    = 6;
   localparam logic [K_W-1:0] K_FLUSH = 6'd40;

   localparam int SERIES_TERMS = 12;
   localparam int DIV_STEPS    = 31;

   localparam int CSR_DATA_W  = 3;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [2:0] {
      FN_TANH    = 3'd0,
      FN_SIGMOID = 3'd1,
      FN_RELU    = 3'd2,
      FN_ELU     = 3'd3,
      FN_LEAKY   = 3'd4,
      FN_LINEAR  = 3'd5
   } fn_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FUNC  = 1'b0,
      CSR_DERIV = 1'b1
   } csr_type;

   typedef struct packed {
      logic   valid;
      fn_type func;
      logic   deriv;
      logic   neg;
   } ctl_type;

endpackage

// File: rtl/afu_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_req_if
// Input word channel: valid/ready handshake with the pre-activation value.
// ----------------------------------------------------------------------------
interface afu_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

// File: rtl/afu_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_rsp_if
// Result word channel: valid/ready handshake with the activation result.
// ----------------------------------------------------------------------------
interface afu_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] y_value;

   modport source (output valid, output y_value, input ready);
   modport sink   (input valid, input y_value, output ready);
endinterface

// File: rtl/activation_function_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// activation_function_unit_top
// Pipeline stages: 4 range reduction, 37 exp series, 32 divider, 3 result.
// Throughput: one word per cycle; a stalled result holds the whole pipeline.
// Reset: clears all valid bits, selects sigmoid, function value (not slope).
// ----------------------------------------------------------------------------
module activation_function_unit_top #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   afu_req_if.sink                           req_chan,
   afu_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [afu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [afu_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   afu_pkg::fn_type func_ff;
   logic            deriv_ff;
   logic            adv;
   logic            post_valid;

   afu_pkg::ctl_type            in_ctl, rr_ctl, ex_ctl, dv_ctl;
   logic [DATA_WIDTH-1:0]       rr_mag, ex_mag, dv_mag;
   logic [afu_pkg::K_W-1:0]     rr_k;
   logic [29:0]                 rr_r;
   logic [30:0]                 ex_e, dv_e, dv_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff  <= afu_pkg::FN_SIGMOID;
         deriv_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (afu_pkg::csr_type'(csr_index))
            afu_pkg::CSR_FUNC:  func_ff  <= afu_pkg::fn_type'(csr_wdata);
            afu_pkg::CSR_DERIV: deriv_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // advance everything unless the output word is stuck
   assign adv            = !post_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      in_ctl.valid = req_chan.valid;
      in_ctl.func  = func_ff;
      in_ctl.deriv = deriv_ff;
      in_ctl.neg   = 1'b0;
   end

   afu_range_reduce #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_range (
      .clock(clock), .reset(reset), .adv(adv),
      .in_ctl(in_ctl), .in_x(req_chan.x_value),
      .out_ctl(rr_ctl), .out_mag(rr_mag), .out_k(rr_k), .out_r(rr_r)
   );

   afu_exp_series #(.DATA_WIDTH(DATA_WIDTH)) u_exp (
      .clock(clock), .reset(reset), .adv(adv),
      .in_ctl(rr_ctl), .in_mag(rr_mag), .in_k(rr_k), .in_r(rr_r),
      .out_ctl(ex_ctl), .out_mag(ex_mag), .out_e(ex_e)
   );

   afu_sig_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_ctl(ex_ctl), .in_mag(ex_mag), .in_e(ex_e),
      .out_ctl(dv_ctl), .out_mag(dv_mag), .out_e(dv_e), .out_s(dv_s)
   );

   afu_post #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_post (
      .clock(clock), .reset(reset), .adv(adv),
      .in_ctl(dv_ctl), .in_mag(dv_mag), .in_e(dv_e), .in_s(dv_s),
      .out_valid(post_valid), .out_y(rsp_chan.y_value)
   );

   assign rsp_chan.valid = post_valid;
endmodule

// File: rtl/afu_range_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_range_reduce
// Four stages: sign/magnitude split and clamp, compare against multiples of
// ln2, quotient count, remainder. Gives k and r with t = k*ln2 + r.
// ----------------------------------------------------------------------------
module afu_range_reduce #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  afu_pkg::ctl_type             in_ctl,
   input  logic signed [DATA_WIDTH-1:0] in_x,
   output afu_pkg::ctl_type             out_ctl,
   output logic [DATA_WIDTH-1:0]        out_mag,
   output logic [afu_pkg::K_W-1:0]      out_k,
   output logic [29:0]                  out_r
);
   localparam int TW = (DATA_WIDTH + 1 > FRAC_BITS + 6) ? DATA_WIDTH + 1 : FRAC_BITS + 6;
   localparam logic [TW-1:0] CAP = TW'(32) << FRAC_BITS;
   localparam logic [afu_pkg::BIG_W-1:0] BIG_CAP = afu_pkg::BIG_W'(1) << 35;

   afu_pkg::ctl_type s1_ctl_in, s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic [DATA_WIDTH-1:0] s1_mag_in, s1_mag_ff, s2_mag_ff, s3_mag_ff, s4_mag_ff;
   logic [TW-1:0] t_wide;
   logic [afu_pkg::BIG_W-1:0] s1_big_in, s1_big_ff, s2_big_ff, s3_big_ff;
   logic [afu_pkg::K_MAX-1:0] s2_ge_in, s2_ge_ff;
   logic [afu_pkg::K_W-1:0] s3_k_in, s3_k_ff, s4_k_ff;
   logic [29:0] s4_r_in, s4_r_ff;

   always_comb begin
      s1_ctl_in     = in_ctl;
      s1_ctl_in.neg = in_x[DATA_WIDTH-1];
      s1_mag_in     = in_x[DATA_WIDTH-1] ? DATA_WIDTH'(~in_x + 1'b1) : DATA_WIDTH'(in_x);
      // shifted tanh runs the sigmoid path at twice the argument
      if (in_ctl.func == afu_pkg::FN_TANH) begin
         t_wide = TW'({s1_mag_in, 1'b0});
      end else begin
         t_wide = TW'(s1_mag_in);
      end
      if (t_wide > CAP) begin
         s1_big_in = BIG_CAP;
      end else begin
         s1_big_in = afu_pkg::BIG_W'(t_wide) << (afu_pkg::IQ - FRAC_BITS);
      end
   end

   for (genvar k = 1; k <= afu_pkg::K_MAX; k++) begin : g_thr
      localparam logic [afu_pkg::BIG_W-1:0] THR =
         afu_pkg::BIG_W'(k) * afu_pkg::BIG_W'(afu_pkg::LN2_Q30);
      assign s2_ge_in[k-1] = (s1_big_ff >= THR);
   end

   always_comb begin
      s3_k_in = afu_pkg::K_W'($countones(s2_ge_ff));
      s4_r_in = 30'(s3_big_ff - afu_pkg::BIG_W'(s3_k_ff) * afu_pkg::BIG_W'(afu_pkg::LN2_Q30));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff <= s1_mag_in;
         s1_big_ff <= s1_big_in;
         s2_mag_ff <= s1_mag_ff;
         s2_big_ff <= s1_big_ff;
         s2_ge_ff  <= s2_ge_in;
         s3_mag_ff <= s2_mag_ff;
         s3_big_ff <= s2_big_ff;
         s3_k_ff   <= s3_k_in;
         s4_mag_ff <= s3_mag_ff;
         s4_k_ff   <= s3_k_ff;
         s4_r_ff   <= s4_r_in;
      end
   end

   assign out_ctl = s4_ctl_ff;
   assign out_mag = s4_mag_ff;
   assign out_k   = s4_k_ff;
   assign out_r   = s4_r_ff;
endmodule

// File: rtl/afu_exp_series.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_exp_series
// exp(-r) by a 12-term Horner series, three stages per term (multiply,
// reciprocal multiply, correct and subtract), then a rounded shift by k.
// ----------------------------------------------------------------------------
module afu_exp_series #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  afu_pkg::ctl_type        in_ctl,
   input  logic [DATA_WIDTH-1:0]   in_mag,
   input  logic [afu_pkg::K_W-1:0] in_k,
   input  logic [29:0]             in_r,
   output afu_pkg::ctl_type        out_ctl,
   output logic [DATA_WIDTH-1:0]   out_mag,
   output logic [30:0]             out_e
);
   localparam int TERMS = afu_pkg::SERIES_TERMS;
   localparam int NST   = 3 * TERMS + 1;
   localparam int RN    = 3 * (TERMS - 1);

   afu_pkg::ctl_type        ctl_ff [NST];
   logic [DATA_WIDTH-1:0]   mag_ff [NST];
   logic [afu_pkg::K_W-1:0] k_ff   [NST-1];
   logic [29:0]             r_ff   [RN];
   logic [30:0]             p_ff   [TERMS];
   logic [30:0]             e_in, e_ff;
   logic [30:0]             p_sh;

   for (genvar s = 0; s < NST; s++) begin : g_side
      afu_pkg::ctl_type      ctl_in;
      logic [DATA_WIDTH-1:0] mag_in;
      if (s == 0) begin : g_head
         assign ctl_in = in_ctl;
         assign mag_in = in_mag;
      end else begin : g_body
         assign ctl_in = ctl_ff[s-1];
         assign mag_in = mag_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_in;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            mag_ff[s] <= mag_in;
         end
      end
   end

   for (genvar s = 0; s < NST - 1; s++) begin : g_kline
      always_ff @(posedge clock) begin
         if (adv) begin
            k_ff[s] <= (s == 0) ? in_k : k_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   for (genvar s = 0; s < RN; s++) begin : g_rline
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[s] <= (s == 0) ? in_r : r_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   for (genvar j = 0; j < TERMS; j++) begin : g_term
      localparam logic [29:0] DIVN  = 30'(TERMS - j);
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / (TERMS - j));
      logic [30:0] p_in;
      logic [29:0] r_in;
      logic [60:0] prod_ff;
      logic [29:0] v_ff;
      logic [62:0] vr_ff;
      logic [29:0] q_est, rem, q;

      if (j == 0) begin : g_first
         assign p_in = afu_pkg::IONE;
         assign r_in = in_r;
      end else begin : g_next
         assign p_in = p_ff[j-1];
         assign r_in = r_ff[3*j-1];
      end

      // quotient estimate is exact or one low; one compare fixes it
      always_comb begin
         q_est = vr_ff[61:32];
         rem   = v_ff - 30'(q_est * DIVN);
         q     = q_est + 30'(rem >= DIVN);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff <= 61'(r_in) * 61'(p_in);
            v_ff    <= prod_ff[59:30];
            vr_ff   <= 63'(prod_ff[59:30]) * 63'(RECIP);
            p_ff[j] <= afu_pkg::IONE - 31'(q);
         end
      end
   end

   // rounded shift by k; far out of range flushes to zero
   always_comb begin
      p_sh = p_ff[TERMS-1] >> (k_ff[NST-2] - 1'b1);
      if (k_ff[NST-2] >= afu_pkg::K_FLUSH) begin
         e_in = '0;
      end else if (k_ff[NST-2] == '0) begin
         e_in = p_ff[TERMS-1];
      end else begin
         e_in = 31'((32'(p_sh) + 32'd1) >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff <= e_in;
      end
   end

   assign out_ctl = ctl_ff[NST-1];
   assign out_mag = mag_ff[NST-1];
   assign out_e   = e_ff;
endmodule

// File: rtl/afu_sig_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_sig_div
// Sigmoid by pipelined restoring division: num / (1 + e), rounded, one
// quotient bit per stage. e rides along for the ELU path.
// ----------------------------------------------------------------------------
module afu_sig_div #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  afu_pkg::ctl_type      in_ctl,
   input  logic [DATA_WIDTH-1:0] in_mag,
   input  logic [30:0]           in_e,
   output afu_pkg::ctl_type      out_ctl,
   output logic [DATA_WIDTH-1:0] out_mag,
   output logic [30:0]           out_e,
   output logic [30:0]           out_s
);
   localparam int NS = afu_pkg::DIV_STEPS;

   afu_pkg::ctl_type      ctl_ff [NS+1];
   logic [DATA_WIDTH-1:0] mag_ff [NS+1];
   logic [30:0]           e_ff   [NS+1];
   logic [31:0]           rem_ff [NS];
   logic [30:0]           low_ff [NS];
   logic [31:0]           den_ff [NS];
   logic [30:0]           q_ff   [1:NS];

   logic [30:0] num;
   logic [31:0] den;
   logic [60:0] dividend;

   always_comb begin
      num      = in_ctl.neg ? in_e : afu_pkg::IONE;
      den      = 32'(afu_pkg::IONE) + 32'(in_e);
      dividend = {num[30:0], 30'b0} + 61'(den >> 1);
   end

   for (genvar s = 0; s <= NS; s++) begin : g_side
      afu_pkg::ctl_type      ctl_in;
      logic [DATA_WIDTH-1:0] mag_in;
      logic [30:0]           e_in;
      if (s == 0) begin : g_head
         assign ctl_in = in_ctl;
         assign mag_in = in_mag;
         assign e_in   = in_e;
      end else begin : g_body
         assign ctl_in = ctl_ff[s-1];
         assign mag_in = mag_ff[s-1];
         assign e_in   = e_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_in;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            mag_ff[s] <= mag_in;
            e_ff[s]   <= e_in;
         end
      end
   end

   // top dividend bits start the remainder; they stay below the divisor
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= 32'(dividend[60:31]);
         low_ff[0] <= dividend[30:0];
         den_ff[0] <= den;
      end
   end

   for (genvar i = 1; i <= NS; i++) begin : g_step
      logic [32:0] trial;
      logic        qbit;
      logic [31:0] rem_in;
      logic [30:0] q_in;

      always_comb begin
         trial  = {rem_ff[i-1], low_ff[i-1][30]};
         qbit   = (trial >= {1'b0, den_ff[i-1]});
         rem_in = qbit ? 32'(trial - {1'b0, den_ff[i-1]}) : trial[31:0];
      end

      if (i == 1) begin : g_q0
         assign q_in = 31'(qbit);
      end else begin : g_qn
         assign q_in = {q_ff[i-1][29:0], qbit};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[i] <= q_in;
         end
      end

      if (i < NS) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i] <= rem_in;
               low_ff[i] <= {low_ff[i-1][29:0], 1'b0};
               den_ff[i] <= den_ff[i-1];
            end
         end
      end
   end

   assign out_ctl = ctl_ff[NS];
   assign out_mag = mag_ff[NS];
   assign out_e   = e_ff[NS];
   assign out_s   = q_ff[NS];
endmodule

// File: rtl/afu_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_post
// Result stages: products for derivatives and ELU, per-function selection
// and rounding to the output format, saturation into the output register.
// ----------------------------------------------------------------------------
module afu_post #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  afu_pkg::ctl_type             in_ctl,
   input  logic [DATA_WIDTH-1:0]        in_mag,
   input  logic [30:0]                  in_e,
   input  logic [30:0]                  in_s,
   output logic                         out_valid,
   output logic signed [DATA_WIDTH-1:0] out_y
);
   localparam int MW  = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2;
   localparam int WW  = DATA_WIDTH + 2;
   localparam int LKS = DATA_WIDTH + 2;
   localparam logic [63:0] LK_RECIP64 = (64'd1 << LKS) / 64'd10;
   localparam logic [DATA_WIDTH-2:0] LK_RECIP = LK_RECIP64[DATA_WIDTH-2:0];
   localparam int LQW = WW + DATA_WIDTH - 1;
   localparam logic [MW-1:0] ONE_F = MW'(1) << FRAC_BITS;
   localparam logic [63:0] LK_D64 = ((64'd1 << FRAC_BITS) * 64'd2 + 64'd5) / 64'd10;
   localparam logic [MW-1:0] LK_D = LK_D64[MW-1:0];
   localparam logic [31:0] RND = 32'd1 << (afu_pkg::IQ - FRAC_BITS - 1);
   localparam logic [MW-1:0] LIM = MW'(1) << (DATA_WIDTH - 1);
   localparam logic [WW-1:0] TEN = WW'(10);

   afu_pkg::ctl_type p1_ctl_ff, p2_ctl_ff;
   logic                  p3_valid_ff;
   logic [DATA_WIDTH-1:0] p1_mag_ff;
   logic [30:0]           p1_s_ff;
   logic [61:0]           p1_a_ff;
   logic [58:0]           p1_pe_ff, p1_pne_ff;
   logic [WW-1:0]         p1_w_ff;
   logic [LQW-1:0]        p1_lq_ff;
   logic [WW-1:0]         w_in;
   logic [30:0]           om;

   logic [30:0]   m_sd, m_td, m_ed, m_ev, m_sel;
   logic [WW-1:0] lq_est, lq_rem, lq;
   logic [MW-1:0] v_q, direct;
   logic          use_q, neg_o;
   logic [MW-1:0] p2_mag_in, p2_mag_ff;
   logic          p2_neg_ff;
   logic [MW-1:0] clip;
   logic [DATA_WIDTH-1:0] y_in, y_ff;

   always_comb begin
      om   = afu_pkg::IONE - in_s;
      w_in = WW'({in_mag, 1'b0}) + WW'(5);
   end

   always_comb begin
      m_sd   = 31'((63'(p1_a_ff) + 63'(afu_pkg::IHALF)) >> afu_pkg::IQ);
      m_td   = 31'(({1'b0, p1_a_ff, 1'b0} + 64'(afu_pkg::IHALF)) >> afu_pkg::IQ);
      m_ed   = 31'((60'(p1_pe_ff) + 60'(afu_pkg::IHALF)) >> afu_pkg::IQ);
      m_ev   = 31'((60'(p1_pne_ff) + 60'(afu_pkg::IHALF)) >> afu_pkg::IQ);
      lq_est = WW'(p1_lq_ff >> LKS);
      lq_rem = p1_w_ff - WW'(lq_est * TEN);
      lq     = lq_est + WW'(lq_rem >= TEN);
      use_q  = 1'b0;
      neg_o  = 1'b0;
      m_sel  = p1_s_ff;
      direct = MW'(p1_mag_ff);
      case (p1_ctl_ff.func)
         afu_pkg::FN_TANH: begin
            use_q = 1'b1;
            m_sel = p1_ctl_ff.deriv ? m_td : p1_s_ff;
         end
         afu_pkg::FN_SIGMOID: begin
            use_q = 1'b1;
            m_sel = p1_ctl_ff.deriv ? m_sd : p1_s_ff;
         end
         afu_pkg::FN_RELU: begin
            if (p1_ctl_ff.neg) direct = '0;
            else if (p1_ctl_ff.deriv) direct = ONE_F;
         end
         afu_pkg::FN_ELU: begin
            if (p1_ctl_ff.neg) begin
               use_q = 1'b1;
               neg_o = !p1_ctl_ff.deriv;
               m_sel = p1_ctl_ff.deriv ? m_ed : m_ev;
            end else if (p1_ctl_ff.deriv) begin
               direct = ONE_F;
            end
         end
         afu_pkg::FN_LEAKY: begin
            if (p1_ctl_ff.deriv) begin
               direct = p1_ctl_ff.neg ? LK_D : ONE_F;
            end else if (p1_ctl_ff.neg) begin
               neg_o  = 1'b1;
               direct = MW'(lq);
            end
         end
         default: begin
            // linear, and the unused selector codes
            neg_o = !p1_ctl_ff.deriv && p1_ctl_ff.neg;
            if (p1_ctl_ff.deriv) direct = ONE_F;
         end
      endcase
      v_q       = MW'((32'(m_sel) + RND) >> (afu_pkg::IQ - FRAC_BITS));
      p2_mag_in = use_q ? v_q : direct;
   end

   always_comb begin
      if (p2_neg_ff) begin
         clip = (p2_mag_ff > LIM) ? LIM : p2_mag_ff;
         y_in = DATA_WIDTH'(~clip + 1'b1);
      end else begin
         clip = (p2_mag_ff > LIM - 1'b1) ? LIM - 1'b1 : p2_mag_ff;
         y_in = DATA_WIDTH'(clip);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff   <= '0;
         p2_ctl_ff   <= '0;
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_ctl_ff   <= in_ctl;
         p2_ctl_ff   <= p1_ctl_ff;
         p3_valid_ff <= p2_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_mag_ff <= in_mag;
         p1_s_ff   <= in_s;
         p1_a_ff   <= 62'(in_s) * 62'(om);
         p1_pe_ff  <= 59'(in_e) * 59'(afu_pkg::FIFTH_Q30);
         p1_pne_ff <= 59'(afu_pkg::IONE - in_e) * 59'(afu_pkg::FIFTH_Q30);
         p1_w_ff   <= w_in;
         p1_lq_ff  <= LQW'(w_in) * LQW'(LK_RECIP);
         p2_mag_ff <= p2_mag_in;
         p2_neg_ff <= neg_o;
         y_ff      <= y_in;
      end
   end

   assign out_valid = p3_valid_ff;
   assign out_y     = y_ff;
endmodule

// File: rtl/afu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afu_checker
// Port-level checks of the activation unit's stall and reset behavior.
// ----------------------------------------------------------------------------
module afu_checker #(
   parameter int DATA_WIDTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_y
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result word is stalled");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with empty output register");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y))
      else $error("stalled result word changed");
endmodule

bind activation_function_unit_top afu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_afu_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_y(rsp_chan.y_value)
);
